>>> hdl/bresenham_line_of_sight_unit_assert.svh
// ----------------------------------------------------------------------------
// bresenham line-of-sight unit assertion macros
// shared property shapes for the concurrent checks of the walk engine
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_OF_SIGHT_UNIT_ASSERT_SVH
`define BRESENHAM_LINE_OF_SIGHT_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define BLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// shared widths, command codes and step-unit structs of the line-of-sight unit
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int MAP_SIDE = 64;
    localparam int ROW_W    = $clog2(MAP_SIDE);
    localparam int COORD_W  = 6;
    localparam int ERR_W    = 8;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [COORD_W-1:0]       coord_t;
    typedef logic signed [ERR_W-1:0]  err_t;

    // operands of one bresenham step
    typedef struct packed {
        coord_t walk_x;
        coord_t walk_y;
        err_t   err;
        coord_t dx;      // |x1 - x0|
        coord_t dy_mag;  // |y1 - y0|, used as a negative term
        logic   sx_neg;  // step x downward
        logic   sy_neg;  // step y downward
    } step_in_t;

    // position and error after one step
    typedef struct packed {
        coord_t walk_x;
        coord_t walk_y;
        err_t   err;
    } step_out_t;

    function automatic logic tile_in_map(input coord_t x, input coord_t y);
        return ({1'b0, x} < (COORD_W+1)'(MAP_SIDE)) && ({1'b0, y} < (COORD_W+1)'(MAP_SIDE));
    endfunction

endpackage

>>> hdl/bls_step_unit.sv
// ----------------------------------------------------------------------------
// bls_step_unit
// one bresenham step: error doubling, two compares, position and error update
// ----------------------------------------------------------------------------
module bls_step_unit (
    input  bls_pkg::step_in_t  step_in,
    output bls_pkg::step_out_t step_out
);
    import bls_pkg::*;

    logic signed [ERR_W:0] e2;
    logic signed [ERR_W:0] dx_s;
    logic signed [ERR_W:0] dy_s;
    logic signed [ERR_W:0] err_sum;
    logic                  take_x;
    logic                  take_y;

    assign dx_s   = $signed({{(ERR_W+1-COORD_W){1'b0}}, step_in.dx});
    assign dy_s   = -$signed({{(ERR_W+1-COORD_W){1'b0}}, step_in.dy_mag});
    assign e2     = {step_in.err, 1'b0};
    assign take_x = (e2 >= dy_s);
    assign take_y = (e2 <= dx_s);

    always_comb begin
        err_sum = {step_in.err[ERR_W-1], step_in.err};
        if (take_x) begin
            err_sum = err_sum + dy_s;
        end
        if (take_y) begin
            err_sum = err_sum + dx_s;
        end
    end

    // position wraps modulo 2**COORD_W
    always_comb begin
        step_out.walk_x = step_in.walk_x;
        step_out.walk_y = step_in.walk_y;
        if (take_x) begin
            step_out.walk_x = step_in.sx_neg ? step_in.walk_x - COORD_W'(1)
                                             : step_in.walk_x + COORD_W'(1);
        end
        if (take_y) begin
            step_out.walk_y = step_in.sy_neg ? step_in.walk_y - COORD_W'(1)
                                             : step_in.walk_y + COORD_W'(1);
        end
        step_out.err = err_sum[ERR_W-1:0];
    end

endmodule

>>> hdl/bresenham_line_of_sight_unit.sv
// ----------------------------------------------------------------------------
// bresenham_line_of_sight_unit
// tile map of blocked bits with a bresenham walk engine for sight queries
// ----------------------------------------------------------------------------
//  channel | ports                                           | direction
//  --------+-------------------------------------------------+----------
//  input   | s_valid s_ready s_command s_tile_x s_tile_y     | in
//          | s_end_x s_end_y s_blocked                       |
//  result  | m_valid m_ready m_line_clear                    | out
//
//  a write transaction updates one map bit in the cycle it is accepted
//  a query visits S_LOOK (end check, row read) and S_TEST (blocked test
//  and step) for each tested tile, then reports from S_DONE; each step
//  waits on the single map read port shared by all steps
//  after reset a clearing pass over all MAP_SIDE rows (one row a cycle)
//  runs with s_ready low
//  the result register lets the next transaction in while a result waits
// ----------------------------------------------------------------------------
module bresenham_line_of_sight_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_command,
    input  bls_pkg::coord_t      s_tile_x,
    input  bls_pkg::coord_t      s_tile_y,
    input  bls_pkg::coord_t      s_end_x,
    input  bls_pkg::coord_t      s_end_y,
    input  logic                 s_blocked,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_line_clear
);
    import bls_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,  // reset sweep over the map rows
        S_IDLE  = 5'b00010,  // waiting for a transaction
        S_LOOK  = 5'b00100,  // end check, row read issued
        S_TEST  = 5'b01000,  // blocked test and bresenham step
        S_DONE  = 5'b10000   // answer waits for the result register
    } state_t;

    state_t           state_reg, state_next;
    logic [ROW_W-1:0] clr_row_reg;

    // walk context
    step_in_t  walk_reg;
    coord_t    end_x_reg;
    coord_t    end_y_reg;
    logic      answer_reg, answer_next;
    step_out_t step_res;

    // map storage: one row of tiles per word
    logic [MAP_SIDE-1:0] map_mem [MAP_SIDE];
    logic [MAP_SIDE-1:0] rd_row_reg;

    logic m_valid_reg;
    logic m_line_clear_reg;

    logic in_xfer;
    logic at_end;
    logic tile_hit;
    logic out_free;

    coord_t dx_in;
    coord_t dy_in;

    assign s_ready      = (state_reg == S_IDLE);
    assign in_xfer      = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_line_clear = m_line_clear_reg;
    assign out_free     = !m_valid_reg || m_ready;

    assign at_end   = (walk_reg.walk_x == end_x_reg) && (walk_reg.walk_y == end_y_reg);
    // tiles off the map count as blocked
    assign tile_hit = !tile_in_map(walk_reg.walk_x, walk_reg.walk_y)
                      || rd_row_reg[walk_reg.walk_x[ROW_W-1:0]];

    assign dx_in = (s_end_x >= s_tile_x) ? s_end_x - s_tile_x : s_tile_x - s_end_x;
    assign dy_in = (s_end_y >= s_tile_y) ? s_end_y - s_tile_y : s_tile_y - s_end_y;

    // shared step arithmetic
    bls_step_unit u_step (
        .step_in  (walk_reg),
        .step_out (step_res)
    );

    // sequencer
    always_comb begin
        state_next  = state_reg;
        answer_next = answer_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_row_reg == ROW_W'(MAP_SIDE - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer && (s_command == CMD_QUERY)) begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                // start equal to end answers clear without any tile check
                if (at_end) begin
                    answer_next = 1'b1;
                    state_next  = S_DONE;
                end else begin
                    state_next  = S_TEST;
                end
            end
            S_TEST: begin
                if (tile_hit) begin
                    answer_next = 1'b0;
                    state_next  = S_DONE;
                end else begin
                    state_next  = S_LOOK;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_row_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_row_reg <= clr_row_reg + ROW_W'(1);
            end
        end
    end

    // walk registers: loaded on a query, advanced by the step unit
    always_ff @(posedge aclk) begin
        answer_reg <= answer_next;
        if (in_xfer && (s_command == CMD_QUERY)) begin
            walk_reg.walk_x <= s_tile_x;
            walk_reg.walk_y <= s_tile_y;
            walk_reg.dx     <= dx_in;
            walk_reg.dy_mag <= dy_in;
            walk_reg.sx_neg <= !(s_tile_x < s_end_x);
            walk_reg.sy_neg <= !(s_tile_y < s_end_y);
            walk_reg.err    <= $signed({{(ERR_W-COORD_W){1'b0}}, dx_in})
                               - $signed({{(ERR_W-COORD_W){1'b0}}, dy_in});
            end_x_reg       <= s_end_x;
            end_y_reg       <= s_end_y;
        end else if ((state_reg == S_TEST) && !tile_hit) begin
            walk_reg.walk_x <= step_res.walk_x;
            walk_reg.walk_y <= step_res.walk_y;
            walk_reg.err    <= step_res.err;
        end
    end

    // map port: row clear, single tile write, registered row read
    always_ff @(posedge aclk) begin
        if (state_reg == S_CLEAR) begin
            map_mem[clr_row_reg] <= '0;
        end else if (in_xfer && (s_command == CMD_WRITE) && tile_in_map(s_tile_x, s_tile_y)) begin
            map_mem[s_tile_y[ROW_W-1:0]][s_tile_x[ROW_W-1:0]] <= s_blocked;
        end
        rd_row_reg <= map_mem[walk_reg.walk_y[ROW_W-1:0]];
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == S_DONE) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_DONE) && out_free) begin
            m_line_clear_reg <= answer_reg;
        end
    end

`include "bresenham_line_of_sight_unit_assert.svh"

    // no transaction is taken while a walk is in flight
    `BLS_ASSERT_NOW(a_busy_not_ready, (state_reg == S_LOOK) || (state_reg == S_TEST), !s_ready, "input ready during walk")
    // a query transaction starts the walk in the next cycle
    `BLS_ASSERT_NEXT(a_query_starts, in_xfer && (s_command == CMD_QUERY), state_reg == S_LOOK, "query did not start walk")
    // a finished walk with a free result slot always presents a result
    `BLS_ASSERT_NEXT(a_done_reports, (state_reg == S_DONE) && out_free, m_valid_reg && (m_line_clear_reg == $past(answer_reg)), "walk answer not reported")
    // no result can appear during the reset clearing pass
    `BLS_ASSERT_NOW(a_clear_quiet, state_reg == S_CLEAR, !m_valid_reg, "result during map clear")

endmodule

>>> tb/line_of_sight_checker.sv
// ----------------------------------------------------------------------------
// line_of_sight_checker
// watches both channels of the line-of-sight unit, keeps its own tile map,
// walks each query and compares every answer with the oldest one predicted
// ----------------------------------------------------------------------------
module line_of_sight_checker (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_ready,
    input  logic            s_command,
    input  bls_pkg::coord_t s_tile_x,
    input  bls_pkg::coord_t s_tile_y,
    input  bls_pkg::coord_t s_end_x,
    input  bls_pkg::coord_t s_end_y,
    input  logic            s_blocked,
    input  logic            m_valid,
    input  logic            m_ready,
    input  logic            m_line_clear,
    output int              mismatch_count,
    output int              pending_count,
    output int              write_count,
    output int              query_count,
    output int              clear_count,
    output int              blocked_count
);
    import bls_pkg::*;

    localparam int TILE_COUNT = MAP_SIDE * MAP_SIDE;
    localparam int COORD_MASK = (1 << COORD_W) - 1;
    localparam int WALK_LIMIT = 256;

    typedef struct {
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
        logic   clear;
    } sight_answer_t;

    sight_answer_t expected_answers[$];
    logic          blocked_tiles[TILE_COUNT];

    // tiles beyond the map edge block sight
    function automatic logic tile_blocks(input int x, input int y);
        if (x >= MAP_SIDE || y >= MAP_SIDE) begin
            return 1'b1;
        end
        return blocked_tiles[y * MAP_SIDE + x];
    endfunction

    // integer bresenham walk, start tile checked, end tile never checked
    function automatic logic sight_is_clear(input coord_t x0, input coord_t y0,
                                            input coord_t x1, input coord_t y1);
        int dx, dy, sx, sy, err, e2, wx, wy;
        dx  = (x1 >= x0) ? int'(x1) - int'(x0) : int'(x0) - int'(x1);
        dy  = (y1 >= y0) ? int'(y0) - int'(y1) : int'(y1) - int'(y0);
        sx  = (x0 < x1) ? 1 : -1;
        sy  = (y0 < y1) ? 1 : -1;
        err = dx + dy;
        wx  = int'(x0);
        wy  = int'(y0);
        for (int n = 0; n < WALK_LIMIT; n++) begin
            if (wx == int'(x1) && wy == int'(y1)) begin
                return 1'b1;
            end
            if (tile_blocks(wx, wy)) begin
                return 1'b0;
            end
            e2 = 2 * err;
            if (e2 >= dy) begin
                err += dy;
                wx = (wx + sx) & COORD_MASK;
            end
            if (e2 <= dx) begin
                err += dx;
                wy = (wy + sy) & COORD_MASK;
            end
        end
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        sight_answer_t head;
        sight_answer_t fresh;
        if (!aresetn) begin
            foreach (blocked_tiles[i]) blocked_tiles[i] = 1'b0;
            expected_answers.delete();
            mismatch_count = 0;
            write_count    = 0;
            query_count    = 0;
            clear_count    = 0;
            blocked_count  = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_answers.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: line_clear=%0b with no query outstanding",
                                 m_line_clear);
                    end
                end else begin
                    head = expected_answers.pop_front();
                    if (head.clear) clear_count++;
                    else blocked_count++;
                    if (m_line_clear !== head.clear) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch: (%0d,%0d)->(%0d,%0d) line_clear exp %0b got %0b",
                                     head.x0, head.y0, head.x1, head.y1,
                                     head.clear, m_line_clear);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_command == CMD_WRITE) begin
                    write_count++;
                    if (int'(s_tile_x) < MAP_SIDE && int'(s_tile_y) < MAP_SIDE) begin
                        blocked_tiles[int'(s_tile_y) * MAP_SIDE + int'(s_tile_x)] = s_blocked;
                    end
                end else begin
                    query_count++;
                    fresh.x0    = s_tile_x;
                    fresh.y0    = s_tile_y;
                    fresh.x1    = s_end_x;
                    fresh.y1    = s_end_y;
                    fresh.clear = sight_is_clear(s_tile_x, s_tile_y, s_end_x, s_end_y);
                    expected_answers.push_back(fresh);
                end
            end
        end
        pending_count = expected_answers.size();
    end

endmodule

>>> tb/bresenham_line_of_sight_unit_test.sv
// ----------------------------------------------------------------------------
// bresenham_line_of_sight_unit_test
// drives map writes and sight queries into the line-of-sight unit with bursty
// input pacing and a stalling result side; the checker beside the block
// predicts every answer and the top reports the verdict
// ----------------------------------------------------------------------------
module bresenham_line_of_sight_unit_test;
    import bls_pkg::*;

    // generous bound, well above the slowest legal run
    localparam int TIMEOUT_CYCLES = 1_500_000;
    // worst walk visits S_LOOK and S_TEST for each tile, plus report
    localparam int DRAIN_CYCLES   = 2 * MAP_SIDE + 8;
    localparam int PHASE_ITEMS    = 150;

    logic   aclk         = 1'b0;
    logic   aresetn      = 1'b0;
    logic   s_valid      = 1'b0;
    logic   s_command    = CMD_WRITE;
    coord_t s_tile_x     = '0;
    coord_t s_tile_y     = '0;
    coord_t s_end_x      = '0;
    coord_t s_end_y      = '0;
    logic   s_blocked    = 1'b0;
    logic   m_ready      = 1'b0;
    logic   s_ready;
    logic   m_valid;
    logic   m_line_clear;

    int mismatch_count;
    int pending_count;
    int write_count;
    int query_count;
    int clear_count;
    int blocked_count;

    // sender pacing: style 0 never idles, 1 short gaps, 2 short plus long gaps
    int   pace_style = 1;
    int   burst_left = 1;
    logic valid_up   = 1'b0;

    // result side stall patterns
    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;
    rx_mode_t rx_mode   = RX_ALWAYS;
    int       rx_left   = 0;
    int       rx_period = 3;
    int       rx_tick   = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    bresenham_line_of_sight_unit DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_tile_x     (s_tile_x),
        .s_tile_y     (s_tile_y),
        .s_end_x      (s_end_x),
        .s_end_y      (s_end_y),
        .s_blocked    (s_blocked),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_line_clear (m_line_clear)
    );

    line_of_sight_checker u_sight_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_tile_x       (s_tile_x),
        .s_tile_y       (s_tile_y),
        .s_end_x        (s_end_x),
        .s_end_y        (s_end_y),
        .s_blocked      (s_blocked),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_line_clear   (m_line_clear),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .write_count    (write_count),
        .query_count    (query_count),
        .clear_count    (clear_count),
        .blocked_count  (blocked_count)
    );

    // result side: a new stall pattern whenever the current stretch runs out
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode   = rx_mode_t'($urandom_range(0, 3));
            rx_left   = $urandom_range(100, 400);
            rx_period = $urandom_range(2, 9);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_ALWAYS: begin
                m_ready <= 1'b1;
            end
            RX_COIN: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            RX_SPARSE: begin
                m_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_ready <= ((rx_tick % rx_period) != 0);
            end
        endcase
    end

    // drop valid once, only if it is up; called at a falling edge
    task automatic lower_valid();
        if (valid_up) begin
            s_valid  <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    // one transaction: drive at the falling edge, hold until accepted,
    // then maybe open a gap before the next burst
    task automatic send_item(input logic cmd, input coord_t x0, input coord_t y0,
                             input coord_t x1, input coord_t y1, input logic blk);
        int gap;
        s_valid   <= 1'b1;
        valid_up  = 1'b1;
        s_command <= cmd;
        s_tile_x  <= x0;
        s_tile_y  <= y0;
        s_end_x   <= x1;
        s_end_y   <= y1;
        s_blocked <= blk;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        @(negedge aclk);
        burst_left--;
        if (burst_left <= 0) begin
            case (pace_style)
                0: gap = 0;
                1: gap = $urandom_range(0, 4);
                default: begin
                    // long gaps let the walk finish at every stage
                    if ($urandom_range(0, 9) == 0) gap = $urandom_range(20, 150);
                    else gap = $urandom_range(0, 3);
                end
            endcase
            if (gap > 0) begin
                lower_valid();
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
    endtask

    // hold off until every query in flight has answered
    task automatic settle();
        lower_valid();
        wait (pending_count == 0);
        @(negedge aclk);
    endtask

    // random phase: writes and queries packed into a window of the map so
    // the blocked density is high enough for both answers to show up
    task automatic run_random_phase(input int items, input int style);
        int     span, base_x, base_y, block_pct;
        logic   cmd, blk;
        coord_t x0, y0, x1, y1;
        pace_style = style;
        span       = $urandom_range(4, MAP_SIDE);
        base_x     = $urandom_range(0, MAP_SIDE - span);
        base_y     = $urandom_range(0, MAP_SIDE - span);
        block_pct  = $urandom_range(5, 60);
        for (int n = 0; n < items; n++) begin
            cmd = ($urandom_range(0, 99) < 55) ? CMD_QUERY : CMD_WRITE;
            x0  = coord_t'(base_x + $urandom_range(0, span - 1));
            y0  = coord_t'(base_y + $urandom_range(0, span - 1));
            x1  = coord_t'(base_x + $urandom_range(0, span - 1));
            y1  = coord_t'(base_y + $urandom_range(0, span - 1));
            blk = ($urandom_range(0, 99) < block_pct);
            // some lines cross the whole map
            if ($urandom_range(0, 4) == 0) begin
                x0 = coord_t'($urandom);
                y0 = coord_t'($urandom);
                x1 = coord_t'($urandom);
                y1 = coord_t'($urandom);
            end
            // start on the end tile
            if (cmd == CMD_QUERY && $urandom_range(0, 19) == 0) begin
                x1 = x0;
                y1 = y0;
            end
            send_item(cmd, x0, y0, x1, y1, blk);
        end
        settle();
    endtask

    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        // reset once; the block then clears its map with s_ready low
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part on a known map
        pace_style = 1;
        // start on end tile, open map
        send_item(CMD_QUERY, 6'd0, 6'd0, 6'd0, 6'd0, 1'b0);
        // both diagonals, the main one in both directions
        send_item(CMD_QUERY, 6'd0, 6'd0, 6'd63, 6'd63, 1'b1);
        send_item(CMD_QUERY, 6'd63, 6'd0, 6'd0, 6'd63, 1'b0);
        send_item(CMD_QUERY, 6'd63, 6'd63, 6'd0, 6'd0, 1'b1);
        // block the far corner, ignored fields at their maximum
        send_item(CMD_WRITE, 6'd63, 6'd63, 6'd63, 6'd63, 1'b1);
        // start on end tile, tile blocked: still clear
        send_item(CMD_QUERY, 6'd63, 6'd63, 6'd63, 6'd63, 1'b0);
        // start tile blocked
        send_item(CMD_QUERY, 6'd63, 6'd63, 6'd0, 6'd0, 1'b0);
        // end tile blocked but never tested
        send_item(CMD_QUERY, 6'd0, 6'd0, 6'd63, 6'd63, 1'b0);
        // block the center and cross it on every axis
        send_item(CMD_WRITE, 6'd32, 6'd32, 6'd5, 6'd9, 1'b1);
        send_item(CMD_QUERY, 6'd0, 6'd0, 6'd63, 6'd63, 1'b0);
        send_item(CMD_QUERY, 6'd0, 6'd32, 6'd63, 6'd32, 1'b0);
        send_item(CMD_QUERY, 6'd32, 6'd0, 6'd32, 6'd63, 1'b1);
        send_item(CMD_QUERY, 6'd31, 6'd31, 6'd32, 6'd32, 1'b0);
        // clear the center, ignored fields at zero
        send_item(CMD_WRITE, 6'd32, 6'd32, 6'd0, 6'd0, 1'b0);
        send_item(CMD_QUERY, 6'd0, 6'd0, 6'd63, 6'd63, 1'b0);
        // origin blocked, one-step lines out of it and into it
        send_item(CMD_WRITE, 6'd0, 6'd0, 6'd21, 6'd42, 1'b1);
        send_item(CMD_QUERY, 6'd0, 6'd0, 6'd1, 6'd0, 1'b0);
        send_item(CMD_QUERY, 6'd1, 6'd1, 6'd0, 6'd0, 1'b0);
        // steep and shallow lines
        send_item(CMD_QUERY, 6'd5, 6'd0, 6'd0, 6'd63, 1'b0);
        send_item(CMD_QUERY, 6'd0, 6'd63, 6'd63, 6'd62, 1'b1);
        send_item(CMD_WRITE, 6'd0, 6'd0, 6'd0, 6'd0, 1'b0);
        send_item(CMD_WRITE, 6'd63, 6'd63, 6'd63, 6'd0, 1'b0);
        send_item(CMD_QUERY, 6'd10, 6'd20, 6'd50, 6'd40, 1'b0);
        settle();

        // random part: one stretch without idling, the rest paced
        run_random_phase(PHASE_ITEMS, 0);
        run_random_phase(PHASE_ITEMS, 1);
        run_random_phase(PHASE_ITEMS, 2);
        run_random_phase(PHASE_ITEMS, 2);
        run_random_phase(PHASE_ITEMS, 1);

        // let any late result show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d map writes and %0d sight queries", write_count, query_count);
        $display("answers compared: %0d clear, %0d blocked, %0d mismatches",
                 clear_count, blocked_count, mismatch_count);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/bls_pkg.sv
hdl/bls_step_unit.sv
hdl/bresenham_line_of_sight_unit.sv
tb/line_of_sight_checker.sv
tb/bresenham_line_of_sight_unit_test.sv
